// ----- sv/ipsd_pkg.sv -----
// ============================================================================
// IPS patch decoder package
// Shared types, codes and constants for the patch stream decoder.
// ============================================================================
`default_nettype none

package ipsd_pkg;

    // Result kinds carried on the result channel.
    typedef enum logic [1:0] {
        KIND_LITERAL    = 2'd0,
        KIND_FILL       = 2'd1,
        KIND_END        = 2'd2,
        KIND_BAD_HEADER = 2'd3
    } kind_t;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_ADDR    = 8'b0000_0010,
        PH_SIZE    = 8'b0000_0100,
        PH_LITERAL = 8'b0000_1000,
        PH_COUNT   = 8'b0001_0000,
        PH_FILL    = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } phase_t;

    localparam int unsigned HDR_LEN = 5;

    // Record address that spells "EOF" and ends the patch.
    localparam logic [23:0] END_MARK = 24'h454F46;

    // Expected header text "PATCH", one character per index.
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h50;
            3'd1:    ch = 8'h41;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h43;
            3'd4:    ch = 8'h48;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ips_patch_stream_decoder.sv -----
// ============================================================================
// IPS patch stream decoder
// Parses an IPS patch one byte per beat and emits literal writes, fill runs,
// end of patch and bad header results.
// ============================================================================
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+----------------------------------
//  byte     | byte_valid / byte_stall    | in_byte[7:0]
//  result   | result_valid / result_stall| result_kind[1:0], target_address
//           |                            | [23:0], run_length[15:0],
//           |                            | data_value[7:0]
//
// Each byte is captured in the input register; the parse step then runs in
// combinational logic and writes the result register, so a byte's result
// passes through both registers. One byte per cycle is sustained as long as
// result_stall stays low.
// rst_n clears the parser to the start of the header and empties both
// registers. byte_stall rises only when the input register holds a byte and
// the result register holds a result that is being stalled.
// After an end of patch or a bad header every further byte is consumed and
// dropped until reset.

`default_nettype none

module ips_patch_stream_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  in_byte,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       result_kind,
    output logic [23:0]      target_address,
    output logic [15:0]      run_length,
    output logic [7:0]       data_value
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_accept;
    logic       advance;

    // The parse step may consume the held byte whenever the result register
    // is free or is being emptied in this cycle.
    assign advance    = in_vld_reg && (!result_valid || !result_stall);
    assign byte_stall = in_vld_reg && result_valid && result_stall;
    assign in_accept  = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    ipsd_pkg::phase_t phase_reg,  phase_next;
    logic [2:0]       hdr_idx_reg, hdr_idx_next;
    logic [23:0]      addr_reg,   addr_next;
    logic [15:0]      size_reg,   size_next;
    logic [15:0]      left_reg,   left_next;
    logic [23:0]      wptr_reg,   wptr_next;
    logic [1:0]       cnt_reg,    cnt_next;

    // Result produced by this step.
    logic             res_emit;
    ipsd_pkg::kind_t  res_kind;
    logic [23:0]      res_addr;
    logic [15:0]      res_len;
    logic [7:0]       res_data;

    logic [23:0]      addr_shift;
    logic [15:0]      size_shift;

    assign addr_shift = {addr_reg[15:0], in_byte_reg};
    assign size_shift = {size_reg[7:0], in_byte_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        addr_next    = addr_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        wptr_next    = wptr_reg;
        cnt_next     = cnt_reg;
        res_emit     = 1'b0;
        res_kind     = ipsd_pkg::KIND_LITERAL;
        res_addr     = '0;
        res_len      = '0;
        res_data     = '0;

        case (phase_reg)
            ipsd_pkg::PH_HEADER:
            begin
                if (hdr_idx_reg > 3'(ipsd_pkg::HDR_LEN - 1) ||
                    in_byte_reg != ipsd_pkg::hdr_char(hdr_idx_reg))
                begin
                    phase_next = ipsd_pkg::PH_ERROR;
                    res_emit   = 1'b1;
                    res_kind   = ipsd_pkg::KIND_BAD_HEADER;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                    if (hdr_idx_reg == 3'(ipsd_pkg::HDR_LEN - 1))
                    begin
                        phase_next = ipsd_pkg::PH_ADDR;
                        cnt_next   = 2'd0;
                        addr_next  = '0;
                    end
                end
            end

            ipsd_pkg::PH_ADDR:
            begin
                addr_next = addr_shift;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg >= 2'd2)
                begin
                    cnt_next = 2'd0;
                    if (addr_shift == ipsd_pkg::END_MARK)
                    begin
                        phase_next = ipsd_pkg::PH_DONE;
                        res_emit   = 1'b1;
                        res_kind   = ipsd_pkg::KIND_END;
                    end
                    else
                    begin
                        size_next  = '0;
                        phase_next = ipsd_pkg::PH_SIZE;
                    end
                end
            end

            ipsd_pkg::PH_SIZE:
            begin
                size_next = size_shift;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg >= 2'd1)
                begin
                    cnt_next = 2'd0;
                    if (size_shift != 16'd0)
                    begin
                        left_next  = size_shift;
                        wptr_next  = addr_reg;
                        phase_next = ipsd_pkg::PH_LITERAL;
                    end
                    else
                    begin
                        phase_next = ipsd_pkg::PH_COUNT;
                    end
                end
            end

            ipsd_pkg::PH_LITERAL:
            begin
                res_emit  = 1'b1;
                res_kind  = ipsd_pkg::KIND_LITERAL;
                res_addr  = wptr_reg;
                res_len   = 16'd1;
                res_data  = in_byte_reg;
                wptr_next = wptr_reg + 24'd1;
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = ipsd_pkg::PH_ADDR;
                    addr_next  = '0;
                    cnt_next   = 2'd0;
                end
            end

            ipsd_pkg::PH_COUNT:
            begin
                size_next = size_shift;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg >= 2'd1)
                begin
                    cnt_next   = 2'd0;
                    phase_next = ipsd_pkg::PH_FILL;
                end
            end

            ipsd_pkg::PH_FILL:
            begin
                phase_next = ipsd_pkg::PH_ADDR;
                cnt_next   = 2'd0;
                addr_next  = '0;
                // A run with a zero count produces nothing.
                if (size_reg != 16'd0)
                begin
                    res_emit = 1'b1;
                    res_kind = ipsd_pkg::KIND_FILL;
                    res_addr = addr_reg;
                    res_len  = size_reg;
                    res_data = in_byte_reg;
                end
            end

            default:
            begin
                // Done or error: bytes are dropped.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ipsd_pkg::PH_HEADER;
            hdr_idx_reg <= '0;
            addr_reg    <= '0;
            size_reg    <= '0;
            left_reg    <= '0;
            wptr_reg    <= '0;
            cnt_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            addr_reg    <= addr_next;
            size_reg    <= size_next;
            left_reg    <= left_next;
            wptr_reg    <= wptr_next;
            cnt_reg     <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             out_vld_reg;
    ipsd_pkg::kind_t  out_kind_reg;
    logic [23:0]      out_addr_reg;
    logic [15:0]      out_len_reg;
    logic [7:0]       out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && res_emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_emit)
        begin
            out_kind_reg <= res_kind;
            out_addr_reg <= res_addr;
            out_len_reg  <= res_len;
            out_data_reg <= res_data;
        end
    end

    assign result_valid   = out_vld_reg;
    assign result_kind    = out_kind_reg;
    assign target_address = out_addr_reg;
    assign run_length     = out_len_reg;
    assign data_value     = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_end_states_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ipsd_pkg::PH_DONE || phase_reg == ipsd_pkg::PH_ERROR)
        |=> (phase_reg == ipsd_pkg::PH_DONE || phase_reg == ipsd_pkg::PH_ERROR))
        else $error("parser left the done or error phase");

    a_no_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ipsd_pkg::PH_DONE || phase_reg == ipsd_pkg::PH_ERROR)
        |-> !res_emit)
        else $error("result produced after end of patch or bad header");

    a_literal_len_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == ipsd_pkg::KIND_LITERAL)
        |-> run_length == 16'd1)
        else $error("literal write with a length other than one");

    a_header_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= 3'(ipsd_pkg::HDR_LEN))
        else $error("header index out of range");

    a_result_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

// ----- test/tb_ips_patch_stream_decoder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// IPS patch stream decoder testbench
// Streams one IPS patch into the decoder byte by byte. A local parser
// predicts every literal write, fill run, end of patch and bad header
// result. A monitor compares the results field by field in arrival order.
// Both channels idle and stall in random bursts.
// ============================================================================

module tb_ips_patch_stream_decoder;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    // A byte's result passes through the input and result registers, so the
    // settling time covers anything still inside the pipeline.
    localparam int unsigned SETTLE_CYCLES = 8;

    // The five header characters, "PATCH".
    localparam logic [7:0] PATCH_TEXT [0:4] = '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48};

    // One decoded patch operation as it appears on the result channel.
    typedef struct packed {
        ipsd_pkg::kind_t kind;
        logic [23:0]     addr;
        logic [15:0]     len;
        logic [7:0]      data;
    } patch_op_t;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  in_byte;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  result_kind;
    logic [23:0] target_address;
    logic [15:0] run_length;
    logic [7:0]  data_value;

    // Operations predicted from accepted bytes, oldest first.
    patch_op_t   pending_ops[$];

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned bytes_sent    = 0;

    // Random idling on the byte side and on the result side. Both are
    // switched off for the last stretch of the run.
    bit          sender_idle_on = 1'b1;
    bit          sink_idle_on   = 1'b1;
    // A long hold-off requested by a test; counted down by the sink process.
    int unsigned sink_hold_left = 0;

    // Parser state mirrored by the predictor.
    ipsd_pkg::phase_t parse_state = ipsd_pkg::PH_HEADER;
    logic [2:0]  hdr_pos     = '0;
    logic [23:0] rec_addr    = '0;
    logic [15:0] len_acc     = '0;
    logic [15:0] lit_left    = '0;
    logic [23:0] lit_ptr     = '0;
    logic [1:0]  field_cnt   = '0;

    ips_patch_stream_decoder u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .in_byte        (in_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_kind    (result_kind),
        .target_address (target_address),
        .run_length     (run_length),
        .data_value     (data_value)
    );

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The watchdog ends a hung run. The limit is far above the slowest
    // legal run, where every byte waits out the longest gap and every result
    // the longest stall.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic patch_op_t make_op(ipsd_pkg::kind_t kind, logic [23:0] addr,
                                          logic [15:0] len, logic [7:0] data);
        patch_op_t op;
        op.kind = kind;
        op.addr = addr;
        op.len  = len;
        op.data = data;
        return op;
    endfunction

    // Advances the mirrored parser by one accepted byte and queues the
    // operation that the byte causes, if any.
    task automatic decode_byte(input logic [7:0] b);
        begin
            case (parse_state)
                ipsd_pkg::PH_HEADER:
                begin
                    // The header is flagged at the first byte that differs.
                    if (hdr_pos > 3'd4 || b != PATCH_TEXT[hdr_pos])
                    begin
                        parse_state = ipsd_pkg::PH_ERROR;
                        pending_ops.push_back(make_op(ipsd_pkg::KIND_BAD_HEADER,
                                                      '0, '0, '0));
                    end
                    else
                    begin
                        hdr_pos = hdr_pos + 3'd1;
                        if (hdr_pos == 3'd5)
                        begin
                            parse_state = ipsd_pkg::PH_ADDR;
                            field_cnt   = '0;
                            rec_addr    = '0;
                        end
                    end
                end
                ipsd_pkg::PH_ADDR:
                begin
                    rec_addr  = {rec_addr[15:0], b};
                    field_cnt = field_cnt + 2'd1;
                    if (field_cnt == 2'd3)
                    begin
                        field_cnt = '0;
                        if (rec_addr == ipsd_pkg::END_MARK)
                        begin
                            parse_state = ipsd_pkg::PH_DONE;
                            pending_ops.push_back(make_op(ipsd_pkg::KIND_END,
                                                          '0, '0, '0));
                        end
                        else
                        begin
                            len_acc     = '0;
                            parse_state = ipsd_pkg::PH_SIZE;
                        end
                    end
                end
                ipsd_pkg::PH_SIZE:
                begin
                    len_acc   = {len_acc[7:0], b};
                    field_cnt = field_cnt + 2'd1;
                    if (field_cnt == 2'd2)
                    begin
                        field_cnt = '0;
                        if (len_acc != '0)
                        begin
                            lit_left    = len_acc;
                            lit_ptr     = rec_addr;
                            parse_state = ipsd_pkg::PH_LITERAL;
                        end
                        else
                        begin
                            parse_state = ipsd_pkg::PH_COUNT;
                        end
                    end
                end
                ipsd_pkg::PH_LITERAL:
                begin
                    pending_ops.push_back(make_op(ipsd_pkg::KIND_LITERAL, lit_ptr,
                                                  16'd1, b));
                    // The write pointer wraps at the top of the 24-bit space.
                    lit_ptr  = lit_ptr + 24'd1;
                    lit_left = lit_left - 16'd1;
                    if (lit_left == '0)
                    begin
                        parse_state = ipsd_pkg::PH_ADDR;
                        rec_addr    = '0;
                        field_cnt   = '0;
                    end
                end
                ipsd_pkg::PH_COUNT:
                begin
                    len_acc   = {len_acc[7:0], b};
                    field_cnt = field_cnt + 2'd1;
                    if (field_cnt == 2'd2)
                    begin
                        field_cnt   = '0;
                        parse_state = ipsd_pkg::PH_FILL;
                    end
                end
                ipsd_pkg::PH_FILL:
                begin
                    parse_state = ipsd_pkg::PH_ADDR;
                    field_cnt   = '0;
                    // A run with a zero count produces nothing.
                    if (len_acc != '0)
                        pending_ops.push_back(make_op(ipsd_pkg::KIND_FILL, rec_addr,
                                                      len_acc, b));
                    rec_addr = '0;
                end
                default:
                begin
                    // After end of patch or a bad header every byte is dropped.
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            error_count++;
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        begin
            if (got !== want)
                report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_result();
        patch_op_t want;
        begin
            if (pending_ops.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d addr %0h len %0h data %0h",
                                          result_kind, target_address, run_length,
                                          data_value));
            end
            else
            begin
                want = pending_ops.pop_front();
                check_field("result_kind", result_kind, want.kind);
                check_field("target_address", target_address, want.addr);
                check_field("run_length", run_length, want.len);
                check_field("data_value", data_value, want.data);
            end
        end
    endtask

    // All sampling happens at the rising edge, before the block's registers
    // update, so a beat is seen exactly as the block sees it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                decode_byte(in_byte);
            if (result_valid && !result_stall)
                check_result();
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts plus the long hold-off on request.
    // ------------------------------------------------------------------------

    initial
    begin : sink_proc
        int unsigned burst_left;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_left > 0)
            begin
                result_stall <= 1'b1;
                sink_hold_left--;
            end
            else if (burst_left > 0)
            begin
                result_stall <= 1'b1;
                burst_left--;
            end
            else if (sink_idle_on && $urandom_range(0, 9) == 0)
            begin
                result_stall <= 1'b1;
                burst_left = $urandom_range(1, 17) - 1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // Offers one byte and returns once its beat has been taken. Valid stays
    // high between back-to-back bytes; a random gap drops it before the byte
    // is offered.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        begin
            gap = 0;
            if (sender_idle_on && $urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 17);
            @(negedge clk);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                in_byte    <= 8'($urandom);
                repeat (gap) @(negedge clk);
            end
            byte_valid <= 1'b1;
            in_byte    <= b;
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
            bytes_sent++;
        end
    endtask

    // Stops offering bytes until every predicted result has arrived and the
    // pipeline has had time to settle.
    task automatic drain_results();
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
            while (pending_ops.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic send_addr(input logic [23:0] addr);
        begin
            send_byte(addr[23:16]);
            send_byte(addr[15:8]);
            send_byte(addr[7:0]);
        end
    endtask

    task automatic send_literal_record(input logic [23:0] addr, input logic [15:0] size);
        begin
            send_addr(addr);
            send_byte(size[15:8]);
            send_byte(size[7:0]);
            repeat (size) send_byte(8'($urandom));
        end
    endtask

    task automatic send_fill_record(input logic [23:0] addr, input logic [15:0] count,
                                    input logic [7:0] fill);
        begin
            send_addr(addr);
            send_byte(8'h00);
            send_byte(8'h00);
            send_byte(count[15:8]);
            send_byte(count[7:0]);
            send_byte(fill);
        end
    endtask

    // Record addresses: mostly random, sometimes one of the corner values
    // (zero, top of space, near misses of the end marker, the byte-swapped
    // marker and an alternating pattern).
    function automatic logic [23:0] pick_addr();
        logic [23:0] corner [0:7];
        corner = '{24'h000000, 24'hFFFFFF, 24'hFFFFFE, 24'h454F45,
                   24'h454F47, 24'h454E46, 24'h464F45, 24'h00FF00};
        if ($urandom_range(0, 5) == 0)
            return corner[$urandom_range(0, 7)];
        return 24'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_header();
        begin
            for (int i = 0; i < 5; i++)
                send_byte(PATCH_TEXT[i]);
        end
    endtask

    // A header that breaks at a random character with a random wrong byte.
    task automatic test_bad_header();
        int unsigned pos;
        begin
            pos = $urandom_range(0, 4);
            for (int i = 0; i < pos; i++)
                send_byte(PATCH_TEXT[i]);
            send_byte(PATCH_TEXT[pos] ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic test_directed_records();
        begin
            // Two literal bytes at the top of the address space: the second
            // write wraps to address zero.
            send_addr(24'hFFFFFF);
            send_byte(8'h00);
            send_byte(8'h02);
            send_byte(8'hFF);
            send_byte(8'h00);
            // A run with a zero count emits nothing, here at the reversed
            // end-marker address.
            send_fill_record(24'h464F45, 16'h0000, 8'h5A);
            // The longest possible run.
            send_fill_record(24'h00FF00, 16'hFFFF, 8'hA5);
        end
    endtask

    // The result side holds off for a long stretch while a literal record
    // keeps coming, so both registers fill and the byte side stalls. Then
    // the sender waits for everything to come out.
    task automatic test_backpressure();
        begin
            sink_hold_left = 150;
            send_literal_record(pick_addr(), 16'd24);
            drain_results();
        end
    endtask

    // Well-formed records with random content until about n more bytes
    // have gone out.
    task automatic test_random_records(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        logic [15:0] count;
        begin
            stop_at = bytes_sent + n;
            while (bytes_sent < stop_at)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 6)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_literal_record(pick_addr(), 16'($urandom_range(9, 40)));
                    else
                        send_literal_record(pick_addr(), 16'($urandom_range(1, 8)));
                end
                else if (pick <= 8)
                begin
                    case ($urandom_range(0, 3))
                        0:       count = 16'h0000;
                        1:       count = 16'hFFFF;
                        2:       count = 16'h0001;
                        default: count = 16'($urandom);
                    endcase
                    send_fill_record(pick_addr(), count, 8'($urandom));
                end
                else
                begin
                    // Literal runs near the top of the address space that may straddle its wrap.
                    send_literal_record(24'hFFFFFF - 24'($urandom_range(0, 3)),
                                        16'($urandom_range(1, 8)));
                end
            end
        end
    endtask

    task automatic test_end_of_patch();
        begin
            send_addr(ipsd_pkg::END_MARK);
        end
    endtask

    // Once the parser has stopped, nothing may come out: random bytes,
    // another header and another end marker are all dropped.
    task automatic test_ignored_tail(input int unsigned n_random);
        begin
            repeat (n_random) send_byte(8'($urandom));
            test_header();
            send_addr(ipsd_pkg::END_MARK);
            send_literal_record(24'h000000, 16'd2);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin : main_proc
        bit bad_header_run;
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        in_byte      = 8'h00;
        result_stall = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Only one reset happens, so the parser sees one patch. Most runs
        // decode a full patch; some take the bad header path instead.
        bad_header_run = ($urandom_range(0, 4) == 0);
        if (bad_header_run)
        begin
            test_bad_header();
            test_backpressure();
            // Final stretch at full rate on both sides.
            sender_idle_on = 1'b0;
            sink_idle_on   = 1'b0;
            test_ignored_tail(380);
        end
        else
        begin
            test_header();
            test_directed_records();
            test_backpressure();
            test_random_records(230);
            // Final stretch at full rate on both sides.
            sender_idle_on = 1'b0;
            sink_idle_on   = 1'b0;
            test_random_records(110);
            test_end_of_patch();
            test_ignored_tail(20);
        end

        drain_results();
        if (pending_ops.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_ops.size()));

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
